// File: design/vqs_pkg.sv
package vqs_pkg;

    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int DATA_W      = 32;
    localparam int QVER_W      = 32;
    localparam int STAMP_W     = 8;
    localparam int ENTRY_W     = DATA_W + STAMP_W;

    typedef enum logic [1:0] {
        CMD_ENQ   = 2'd0,
        CMD_DEQ   = 2'd1,
        CMD_QUERY = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SRCH,
        S_SRCH_CMP,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FINISH
    } t_state;

    typedef enum logic [1:0] {
        OSEL_STATUS,
        OSEL_PEND_MID,
        OSEL_FINAL
    } t_out_sel;

    typedef struct packed {
        logic     latch_in;
        logic     do_enq;
        logic     do_deq;
        logic     srch_init;
        logic     srch_upd;
        logic     scan_init;
        logic     rd_scan;
        logic     take_pend;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        t_cmd cmd;
        logic full;
        logic q_empty;
        logic lo_lt_hi;
        logic idx_lt_cnt;
        logic ins_ok;
        logic pend;
        logic slot_free;
    } t_dp_sts;

endpackage

// File: design/vqs_ctrl.sv
module vqs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  vqs_pkg::t_dp_sts  i_sts,
    output vqs_pkg::t_dp_cmd  o_cmd
);

    vqs_pkg::t_state r_state;
    vqs_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vqs_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vqs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = vqs_pkg::S_EXEC;
                end
            end
            vqs_pkg::S_EXEC: begin
                case (i_sts.cmd)
                    vqs_pkg::CMD_ENQ, vqs_pkg::CMD_DEQ: begin
                        if (i_sts.slot_free) begin
                            n_state = vqs_pkg::S_IDLE;
                        end
                    end
                    vqs_pkg::CMD_QUERY: n_state = vqs_pkg::S_SRCH;
                    default:            n_state = vqs_pkg::S_IDLE;
                endcase
            end
            vqs_pkg::S_SRCH: begin
                n_state = i_sts.lo_lt_hi ? vqs_pkg::S_SRCH_CMP : vqs_pkg::S_SCAN_RD;
            end
            vqs_pkg::S_SRCH_CMP: n_state = vqs_pkg::S_SRCH;
            vqs_pkg::S_SCAN_RD: begin
                n_state = i_sts.idx_lt_cnt ? vqs_pkg::S_SCAN_CHK : vqs_pkg::S_FINISH;
            end
            vqs_pkg::S_SCAN_CHK: begin
                if (!i_sts.ins_ok) begin
                    n_state = vqs_pkg::S_FINISH;
                end else if (!i_sts.pend || i_sts.slot_free) begin
                    n_state = vqs_pkg::S_SCAN_RD;
                end
            end
            vqs_pkg::S_FINISH: begin
                if (i_sts.slot_free) begin
                    n_state = vqs_pkg::S_IDLE;
                end
            end
            default: n_state = vqs_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.out_sel = vqs_pkg::OSEL_STATUS;
        o_in_ready    = 1'b0;
        case (r_state)
            vqs_pkg::S_IDLE: begin
                o_in_ready     = 1'b1;
                o_cmd.latch_in = i_in_valid;
            end
            vqs_pkg::S_EXEC: begin
                case (i_sts.cmd)
                    vqs_pkg::CMD_ENQ: begin
                        o_cmd.out_load = i_sts.slot_free;
                        o_cmd.do_enq   = i_sts.slot_free && !i_sts.full;
                    end
                    vqs_pkg::CMD_DEQ: begin
                        o_cmd.out_load = i_sts.slot_free;
                        o_cmd.do_deq   = i_sts.slot_free && !i_sts.q_empty;
                    end
                    vqs_pkg::CMD_QUERY: o_cmd.srch_init = 1'b1;
                    default: ;
                endcase
            end
            vqs_pkg::S_SRCH: begin
                o_cmd.scan_init = !i_sts.lo_lt_hi;
            end
            vqs_pkg::S_SRCH_CMP: begin
                o_cmd.srch_upd = 1'b1;
            end
            vqs_pkg::S_SCAN_RD: begin
                o_cmd.rd_scan = 1'b1;
            end
            vqs_pkg::S_SCAN_CHK: begin
                o_cmd.rd_scan = 1'b1;
                if (i_sts.ins_ok && (!i_sts.pend || i_sts.slot_free)) begin
                    o_cmd.take_pend = 1'b1;
                    o_cmd.out_load  = i_sts.pend;
                    o_cmd.out_sel   = vqs_pkg::OSEL_PEND_MID;
                end
            end
            vqs_pkg::S_FINISH: begin
                o_cmd.out_load = i_sts.slot_free;
                o_cmd.out_sel  = vqs_pkg::OSEL_FINAL;
            end
            default: ;
        endcase
    end

endmodule

// File: design/vqs_datapath.sv
module vqs_datapath (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  vqs_pkg::t_dp_cmd                        i_cmd,
    output vqs_pkg::t_dp_sts                        o_sts,
    input  logic [1:0]                              i_command,
    input  logic signed [vqs_pkg::DATA_W-1:0]       i_item_value,
    input  logic [vqs_pkg::QVER_W-1:0]              i_query_version,
    input  logic                                    i_out_ready,
    output logic                                    o_out_valid,
    output logic signed [vqs_pkg::DATA_W-1:0]       o_out_value,
    output logic                                    o_last_of_run,
    output logic                                    o_snapshot_empty,
    output logic [1:0]                              o_status
);

    logic [vqs_pkg::ENTRY_W-1:0]     r_entry_mem [vqs_pkg::STORE_DEPTH];
    logic [vqs_pkg::STAMP_W-1:0]     r_del_mem   [vqs_pkg::STORE_DEPTH];
    logic [vqs_pkg::ENTRY_W-1:0]     r_entry_rd;
    logic [vqs_pkg::STAMP_W-1:0]     r_del_rd;

    vqs_pkg::t_cmd                   r_cmd;
    logic signed [vqs_pkg::DATA_W-1:0] r_value;
    logic [vqs_pkg::QVER_W-1:0]      r_qver;

    logic [vqs_pkg::CNT_W-1:0]       r_head;
    logic [vqs_pkg::CNT_W-1:0]       r_count;
    logic [vqs_pkg::STAMP_W-1:0]     r_version;
    logic [vqs_pkg::CNT_W-1:0]       r_lo;
    logic [vqs_pkg::CNT_W-1:0]       r_hi;
    logic [vqs_pkg::CNT_W-1:0]       r_idx;
    logic                            r_pend;
    logic signed [vqs_pkg::DATA_W-1:0] r_pend_val;

    logic                            r_out_valid;
    logic signed [vqs_pkg::DATA_W-1:0] r_out_value;
    logic                            r_out_last;
    logic                            r_out_empty;
    vqs_pkg::t_status                r_out_status;

    logic [vqs_pkg::CNT_W:0]         sum;
    logic [vqs_pkg::CNT_W-1:0]       mid;
    logic [vqs_pkg::ADDR_W-1:0]      rd_addr;
    logic                            del_gt;
    logic                            full;
    logic                            q_empty;
    logic                            slot_free;
    vqs_pkg::t_status                op_status;

    assign sum       = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = sum[vqs_pkg::CNT_W:1];
    assign rd_addr   = i_cmd.rd_scan ? r_idx[vqs_pkg::ADDR_W-1:0]
                                     : mid[vqs_pkg::ADDR_W-1:0];
    assign del_gt    = {{(vqs_pkg::QVER_W-vqs_pkg::STAMP_W){1'b0}}, r_del_rd} > r_qver;
    assign full      = (r_count == vqs_pkg::CNT_W'(vqs_pkg::STORE_DEPTH));
    assign q_empty   = (r_head == r_count);
    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        op_status = vqs_pkg::ST_OK;
        if (r_cmd == vqs_pkg::CMD_ENQ && full) begin
            op_status = vqs_pkg::ST_FULL;
        end else if (r_cmd == vqs_pkg::CMD_DEQ && q_empty) begin
            op_status = vqs_pkg::ST_EMPTY;
        end
    end

    always_comb begin
        o_sts            = '0;
        o_sts.cmd        = r_cmd;
        o_sts.full       = full;
        o_sts.q_empty    = q_empty;
        o_sts.lo_lt_hi   = r_lo < r_hi;
        o_sts.idx_lt_cnt = r_idx < r_count;
        o_sts.ins_ok     = {{(vqs_pkg::QVER_W-vqs_pkg::STAMP_W){1'b0}},
                            r_entry_rd[vqs_pkg::STAMP_W-1:0]} <= r_qver;
        o_sts.pend       = r_pend;
        o_sts.slot_free  = slot_free;
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_enq) begin
            r_entry_mem[r_count[vqs_pkg::ADDR_W-1:0]] <= {r_value, r_version};
        end
        if (i_cmd.do_deq) begin
            r_del_mem[r_head[vqs_pkg::ADDR_W-1:0]] <= r_version;
        end
        r_entry_rd <= r_entry_mem[rd_addr];
        r_del_rd   <= r_del_mem[rd_addr];
    end

    // input capture and search / scan registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch_in) begin
            r_cmd   <= vqs_pkg::t_cmd'(i_command);
            r_value <= i_item_value;
            r_qver  <= i_query_version;
        end
        if (i_cmd.srch_init) begin
            r_lo <= '0;
            r_hi <= r_head;
        end else if (i_cmd.srch_upd) begin
            if (del_gt) begin
                r_hi <= mid;
            end else begin
                r_lo <= mid + 1'b1;
            end
        end
        if (i_cmd.scan_init) begin
            r_idx <= r_lo;
        end else if (i_cmd.take_pend) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.take_pend) begin
            r_pend_val <= r_entry_rd[vqs_pkg::ENTRY_W-1:vqs_pkg::STAMP_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_version   <= vqs_pkg::STAMP_W'(1);
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.do_enq) begin
                r_count <= r_count + 1'b1;
            end
            if (i_cmd.do_deq) begin
                r_head <= r_head + 1'b1;
            end
            if (i_cmd.do_enq || i_cmd.do_deq) begin
                r_version <= r_version + 1'b1;
            end
            if (i_cmd.scan_init) begin
                r_pend <= 1'b0;
            end else if (i_cmd.take_pend) begin
                r_pend <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            case (i_cmd.out_sel)
                vqs_pkg::OSEL_STATUS: begin
                    r_out_value  <= '0;
                    r_out_last   <= 1'b1;
                    r_out_empty  <= 1'b0;
                    r_out_status <= op_status;
                end
                vqs_pkg::OSEL_PEND_MID: begin
                    r_out_value  <= r_pend_val;
                    r_out_last   <= 1'b0;
                    r_out_empty  <= 1'b0;
                    r_out_status <= vqs_pkg::ST_OK;
                end
                vqs_pkg::OSEL_FINAL: begin
                    r_out_value  <= r_pend ? r_pend_val : '0;
                    r_out_last   <= 1'b1;
                    r_out_empty  <= !r_pend;
                    r_out_status <= vqs_pkg::ST_OK;
                end
                default: begin
                    r_out_value  <= '0;
                    r_out_last   <= 1'b1;
                    r_out_empty  <= 1'b0;
                    r_out_status <= vqs_pkg::ST_OK;
                end
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_out_value      = r_out_value;
    assign o_last_of_run    = r_out_last;
    assign o_snapshot_empty = r_out_empty;
    assign o_status         = r_out_status;

endmodule

// File: design/versioned_queue_snapshot.sv
// channel | valid       | ready       | fields
// input   | i_in_valid  | o_in_ready  | i_command, i_item_value, i_query_version
// output  | o_out_valid | i_out_ready | o_out_value, o_last_of_run, o_snapshot_empty, o_status
//
// enqueue, dequeue: after accept the EXEC state registers the beat and then returns to idle;
// command 3 gives no beat and goes straight from EXEC back to idle
// query: binary search (up to 7 steps, S_SRCH / S_SRCH_CMP), then a scan streaming values
// (S_SCAN_RD, S_SCAN_CHK) to the final beat; one registered read port per memory sets the pace
// a beat waiting at the output stalls the controller in place; idle still takes the next item
// reset is synchronous, active low; the memories need no clearing after reset
module versioned_queue_snapshot (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_command,
    input  logic signed [vqs_pkg::DATA_W-1:0]  i_item_value,
    input  logic [vqs_pkg::QVER_W-1:0]         i_query_version,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [vqs_pkg::DATA_W-1:0]  o_out_value,
    output logic                               o_last_of_run,
    output logic                               o_snapshot_empty,
    output logic [1:0]                         o_status
);

    vqs_pkg::t_dp_cmd cmd;
    vqs_pkg::t_dp_sts sts;

    vqs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    vqs_datapath u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_command        (i_command),
        .i_item_value     (i_item_value),
        .i_query_version  (i_query_version),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_value      (o_out_value),
        .o_last_of_run    (o_last_of_run),
        .o_snapshot_empty (o_snapshot_empty),
        .o_status         (o_status)
    );

endmodule

// File: design/vqs_checker.sv
module vqs_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_ready,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic signed [vqs_pkg::DATA_W-1:0]  o_out_value,
    input logic                               o_last_of_run,
    input logic                               o_snapshot_empty,
    input logic [1:0]                         o_status
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_value)
            && $stable(o_last_of_run) && $stable(o_status))
        else $error("output beat changed while stalled");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != vqs_pkg::ST_OK |-> o_last_of_run && o_out_value == '0)
        else $error("error status beat not a single zero beat");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_snapshot_empty |->
            o_last_of_run && o_out_value == '0 && o_status == vqs_pkg::ST_OK)
        else $error("empty snapshot beat malformed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("input taken again right after accept");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_status == vqs_pkg::ST_OK || o_status == vqs_pkg::ST_FULL
            || o_status == vqs_pkg::ST_EMPTY)
        else $error("unknown status code");

endmodule

bind versioned_queue_snapshot vqs_checker u_vqs_checker (.*);
